// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Request and status codes and the operation bundle shared by the sorted
// priority queue and its entry store.
// ----------------------------------------------------------------------------
package spq_pkg;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_NOP    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// operation handed to the entry store for one transaction
	typedef struct packed {
		logic       ins;
		logic       rem;
		logic [7:0] value;
		logic [7:0] prio;
	} spq_op_t;

endpackage

// File: rtl/spq_store.sv
// ----------------------------------------------------------------------------
// spq_store
// Row of entry registers kept sorted from highest to lowest priority.
// Insert compares every slot in parallel and shifts the tail down by one;
// remove shifts every slot but the last up by one. Slot 0 is the head.
// ----------------------------------------------------------------------------
module spq_store
	import spq_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int CW    = 5
) (
	input  logic          clk,
	input  spq_op_t       op,
	input  logic [CW-1:0] count,
	output logic [7:0]    head_value,
	output logic [7:0]    head_prio
);

	logic [7:0] value_q [DEPTH];
	logic [7:0] prio_q  [DEPTH];
	logic [7:0] value_d [DEPTH];
	logic [7:0] prio_d  [DEPTH];
	logic       stay    [DEPTH];

	// a slot stays put on insert when it holds an entry at least as urgent
	for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
		assign stay[i] = (CW'(i) < count) && (prio_q[i] >= op.prio);
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_slot
		always_comb begin
			value_d[i] = value_q[i];
			prio_d[i]  = prio_q[i];
			if (op.ins) begin
				if (!stay[i]) begin
					if (i == 0) begin
						value_d[i] = op.value;
						prio_d[i]  = op.prio;
					end else if (stay[(i == 0) ? 0 : i-1]) begin
						value_d[i] = op.value;
						prio_d[i]  = op.prio;
					end else begin
						value_d[i] = value_q[(i == 0) ? 0 : i-1];
						prio_d[i]  = prio_q[(i == 0) ? 0 : i-1];
					end
				end
			end else if (op.rem) begin
				if (i < DEPTH-1) begin
					value_d[i] = value_q[(i < DEPTH-1) ? i+1 : i];
					prio_d[i]  = prio_q[(i < DEPTH-1) ? i+1 : i];
				end
			end
		end

		always_ff @(posedge clk) begin
			value_q[i] <= value_d[i];
			prio_q[i]  <= prio_d[i];
		end
	end

	assign head_value = value_q[0];
	assign head_prio  = prio_q[0];

endmodule

// File: rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue of bytes, each with an 8-bit priority, served
// highest priority first and in arrival order among equal priorities.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (in_valid/in_ready) carries req_type, item_value and
//   item_priority: insert, remove head or clear. Each request gives exactly
//   one transaction on the result channel (out_valid/out_ready) with the
//   removed byte and priority (zero unless a remove succeeded), a status
//   (ok, remove on empty, insert on full) and the fill count afterwards.
//   The request register is loaded when a request is accepted; the parallel
//   compare-and-shift over the entry row then writes the result register
//   once that register is free to advance. One request per cycle is
//   sustained while the receiver does not stall; the per-slot compare
//   against the new priority and the one-slot shift set the path length.
//   If the receiver stalls, the result register holds and the request
//   register fills; in_ready drops only when both are occupied.
//   Reset empties the queue and both channels; entry contents are not
//   cleared, only the count.
// ----------------------------------------------------------------------------
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic [7:0] item_value,
	input  logic [7:0] item_priority,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_value,
	output logic [7:0] out_priority,
	output logic [1:0] status,
	output logic [4:0] fill_count
);

	localparam int CW = $clog2(DEPTH + 1);

	logic          valid_s1;
	req_t          req_s1;
	logic [7:0]    value_s1;
	logic [7:0]    prio_s1;

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;

	logic          out_valid_q;
	logic [7:0]    out_value_q;
	logic [7:0]    out_prio_q;
	status_t       status_q;
	logic [4:0]    fill_q;

	logic          adv;
	logic          fire;
	spq_op_t       op;
	status_t       status_d;
	logic [7:0]    res_value;
	logic [7:0]    res_prio;
	logic [7:0]    head_value;
	logic [7:0]    head_prio;

	assign adv      = !out_valid_q || out_ready;
	assign fire     = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1   <= req_t'(req_type);
			value_s1 <= item_value;
			prio_s1  <= item_priority;
		end
	end

	always_comb begin
		op.ins    = 1'b0;
		op.rem    = 1'b0;
		op.value  = value_s1;
		op.prio   = prio_s1;
		count_d   = count_q;
		status_d  = STAT_OK;
		res_value = '0;
		res_prio  = '0;
		if (fire) begin
			unique case (req_s1)
				REQ_INSERT: begin
					if (count_q == CW'(DEPTH)) begin
						status_d = STAT_FULL;
					end else begin
						op.ins  = 1'b1;
						count_d = count_q + CW'(1);
					end
				end
				REQ_REMOVE: begin
					if (count_q == '0) begin
						status_d = STAT_EMPTY;
					end else begin
						op.rem    = 1'b1;
						count_d   = count_q - CW'(1);
						res_value = head_value;
						res_prio  = head_prio;
					end
				end
				REQ_CLEAR: begin
					count_d = '0;
				end
				REQ_NOP: begin
				end
				default: begin
				end
			endcase
		end
	end

	spq_store #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_store (
		.clk        (clk),
		.op         (op),
		.count      (count_q),
		.head_value (head_value),
		.head_prio  (head_prio)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_value_q <= res_value;
			out_prio_q  <= res_prio;
			status_q    <= status_d;
			fill_q      <= 5'(count_d);
		end
	end

	assign out_valid    = out_valid_q;
	assign out_value    = out_value_q;
	assign out_priority = out_prio_q;
	assign status       = status_q;
	assign fill_count   = fill_q;

endmodule

// File: test/sorted_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Self-checking bench for the sorted priority queue. A driver feeds insert,
// remove, clear and unused requests through the request channel while a
// mirror of the entry row works out each outcome; a monitor compares every
// result transaction with the oldest outcome, with random stalls on both
// channels over the first two thirds of the requests.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
	import spq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QDEPTH      = 16;
	localparam int CLK_PERIOD  = 10;
	localparam int RAND_ITEMS  = 1100;
	localparam int CYCLE_LIMIT = 100000;
	localparam int DRAIN_WAIT  = 8;

	typedef struct packed {
		req_t       kind;
		logic [7:0] value;
		logic [7:0] prio;
	} request_t;

	typedef struct packed {
		logic [7:0] value;
		logic [7:0] prio;
		status_t    stat;
		logic [4:0] fill;
	} outcome_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] req_type = REQ_NOP;
	logic [7:0] item_value = 8'd0;
	logic [7:0] item_priority = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_value;
	logic [7:0] out_priority;
	logic [1:0] status;
	logic [4:0] fill_count;

	// mirror of the entry row, slot 0 is the head
	logic [7:0] row_value [QDEPTH];
	logic [7:0] row_prio [QDEPTH];
	int         row_count = 0;

	request_t   request_q [$];
	outcome_t   outcome_q [$];
	int         total_items = 0;
	int         accepted_count = 0;
	int         mismatch_count = 0;
	int         cycle_count = 0;
	int         n_insert = 0, n_full = 0, n_remove = 0, n_empty = 0;
	int         n_clear = 0, n_nop = 0, peak_fill = 0;

	sorted_priority_queue #(.DEPTH(QDEPTH)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.item_value   (item_value),
		.item_priority(item_priority),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_value    (out_value),
		.out_priority (out_priority),
		.status       (status),
		.fill_count   (fill_count)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// applies one request to the mirror and returns the result it must give
	function automatic outcome_t serve(req_t kind, logic [7:0] val, logic [7:0] pri);
		outcome_t res;
		int pos;
		res = '{value: 8'd0, prio: 8'd0, stat: STAT_OK, fill: 5'd0};
		case (kind)
			REQ_INSERT: begin
				if (row_count >= QDEPTH) begin
					res.stat = STAT_FULL;
					n_full++;
				end else begin
					pos = 0;
					// equal priorities stay ahead of the newcomer
					while (pos < row_count && row_prio[pos] >= pri)
						pos++;
					for (int i = row_count; i > pos; i--) begin
						row_value[i] = row_value[i - 1];
						row_prio[i] = row_prio[i - 1];
					end
					row_value[pos] = val;
					row_prio[pos] = pri;
					row_count++;
					n_insert++;
				end
			end
			REQ_REMOVE: begin
				if (row_count == 0) begin
					res.stat = STAT_EMPTY;
					n_empty++;
				end else begin
					res.value = row_value[0];
					res.prio = row_prio[0];
					for (int i = 1; i < row_count; i++) begin
						row_value[i - 1] = row_value[i];
						row_prio[i - 1] = row_prio[i];
					end
					row_count--;
					n_remove++;
				end
			end
			REQ_CLEAR: begin
				row_count = 0;
				n_clear++;
			end
			default: n_nop++;
		endcase
		if (row_count > peak_fill)
			peak_fill = row_count;
		res.fill = row_count[4:0];
		return res;
	endfunction

	// first third: sender 31 % idle, receiver 51 %; then swapped; then none
	function automatic bit sender_pauses();
		if (accepted_count < total_items / 3)
			return $urandom_range(99) < 31;
		if (accepted_count < 2 * total_items / 3)
			return $urandom_range(99) < 51;
		return 1'b0;
	endfunction

	function automatic bit receiver_pauses();
		if (accepted_count < total_items / 3)
			return $urandom_range(99) < 51;
		if (accepted_count < 2 * total_items / 3)
			return $urandom_range(99) < 31;
		return 1'b0;
	endfunction

	always @(posedge clk) begin : drive
		request_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				outcome_q.push_back(serve(req_t'(req_type), item_value, item_priority));
				accepted_count <= accepted_count + 1;
			end
			// hold the payload until the transaction is taken
			if (!(in_valid && !in_ready)) begin
				if (request_q.size() > 0 && !sender_pauses()) begin
					nxt = request_q.pop_front();
					in_valid <= 1'b1;
					req_type <= nxt.kind;
					item_value <= nxt.value;
					item_priority <= nxt.prio;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : observe
		outcome_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (outcome_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("[%0t] unexpected result: value %0d prio %0d status %0d fill %0d",
							$realtime, out_value, out_priority, status, fill_count);
				end else begin
					want = outcome_q.pop_front();
					if (out_value !== want.value || out_priority !== want.prio ||
							status !== want.stat || fill_count !== want.fill) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("[%0t] mismatch: expected value %0d prio %0d status %0d fill %0d",
								$realtime, want.value, want.prio, want.stat, want.fill);
							$display("    got value %0d prio %0d status %0d fill %0d",
								out_value, out_priority, status, fill_count);
						end
					end
				end
			end
			out_ready <= !receiver_pauses();
		end
	end

	task automatic add(req_t kind, int val, int pri);
		request_q.push_back('{kind: kind, value: val[7:0], prio: pri[7:0]});
	endtask

	initial begin : stimulus
		int made, len, ins_pct, roll, mode;
		bit ties;
		// directed: empty queue, unused code, fill with extremes and ties, full, clear
		add(REQ_REMOVE, 8'hff, 8'hff);
		add(REQ_NOP, 8'h5a, 8'ha5);
		add(REQ_INSERT, 8'hff, 8'hff);
		add(REQ_INSERT, 8'h00, 8'h00);
		add(REQ_INSERT, 8'h01, 8'h80);
		add(REQ_INSERT, 8'h02, 8'h80);
		add(REQ_INSERT, 8'h03, 8'h80);
		add(REQ_INSERT, 8'hfe, 8'hff);
		add(REQ_INSERT, 8'haa, 8'h00);
		add(REQ_INSERT, 8'h55, 8'h7f);
		add(REQ_INSERT, 8'h80, 8'h81);
		add(REQ_INSERT, 8'h7f, 8'h01);
		add(REQ_INSERT, 8'h10, 8'hfe);
		add(REQ_INSERT, 8'h20, 8'h80);
		add(REQ_INSERT, 8'h30, 8'h55);
		add(REQ_INSERT, 8'h40, 8'haa);
		add(REQ_INSERT, 8'h50, 8'h00);
		add(REQ_INSERT, 8'h60, 8'hff);
		add(REQ_INSERT, 8'h99, 8'h99);
		add(REQ_REMOVE, 8'h00, 8'h00);
		add(REQ_REMOVE, 8'hff, 8'hff);
		add(REQ_CLEAR, 8'hff, 8'hff);
		add(REQ_REMOVE, 8'h00, 8'h00);

		// random bursts that lean towards filling, draining or neither
		made = 0;
		while (made < RAND_ITEMS) begin
			mode = $urandom_range(2);
			len = $urandom_range(40, 8);
			ties = $urandom_range(1);
			ins_pct = (mode == 0) ? 84 : (mode == 1) ? 24 : 54;
			for (int k = 0; k < len; k++) begin
				roll = $urandom_range(99);
				request_q.push_back('{
					kind: (roll < 2) ? REQ_CLEAR : (roll < 4) ? REQ_NOP :
						(roll < ins_pct) ? REQ_INSERT : REQ_REMOVE,
					value: 8'($urandom_range(255)),
					prio: ties ? 8'($urandom_range(3) * 85) : 8'($urandom_range(255))});
			end
			made += len;
		end
		total_items = request_q.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (request_q.size() > 0 || in_valid || outcome_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d requests: %0d inserts, %0d refused as full, %0d removes, %0d on empty,",
			accepted_count, n_insert, n_full, n_remove, n_empty);
		$display("%0d clears, %0d unused codes, deepest fill %0d of %0d", n_clear, n_nop,
			peak_fill, QDEPTH);
		if (mismatch_count == 0 && outcome_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatch_count, outcome_q.size());
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timed out after %0d cycles", cycle_count);
		$display("Some tests failed");
		$finish;
	end

endmodule
